// ===== design/tpp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants for the timed pattern player.
// ----------------------------------------------------------------------------
package tpp_pkg;

  // Sample table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int TIME_W   = 48;
  localparam int OFFSET_W = 32;
  localparam int LEVEL_W  = 16;
  localparam int PERIOD_W = 32;

  // Item operation codes.
  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_REPEAT_PERIOD = 1'b0;
  localparam logic CFG_INITIAL_LEVEL = 1'b1;

  // Input beat.
  typedef struct packed {
    logic [1:0]                op;
    logic [OFFSET_W-1:0]       sample_offset;
    logic signed [LEVEL_W-1:0] sample_level;
    logic [TIME_W-1:0]         start_time;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      active;
    logic                      changed;
    logic                      table_full;
  } out_t;

endpackage
`default_nettype wire

// ===== design/timed_pattern_player.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timed_pattern_player
// Plays a table of (offset, level) samples against a 48-bit tick counter.
// ----------------------------------------------------------------------------
// Every item yields one result beat, so the block runs at one item per clock
// while the output side does not stall. The sample table sits in a single
// synchronous memory with one write port and one registered read port; the
// read port always prefetches the sample that follows the armed one, so a
// firing tick can arm the next sample at once. An append to the prefetched
// address in the same cycle is forwarded into the read register. The result
// register is refilled while its beat is taken, so input stalls only while
// the output side stalls.
module timed_pattern_player
  import tpp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire in_t                  item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output out_t                      result,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [PERIOD_W-1:0]  cfg_data
);

  // Sample memory.
  logic [OFFSET_W-1:0] offset_mem [TABLE_DEPTH];
  logic [LEVEL_W-1:0]  level_mem  [TABLE_DEPTH];

  // Configuration registers.
  logic [PERIOD_W-1:0] repeat_period, repeat_period_next;
  logic [LEVEL_W-1:0]  initial_level;

  // Player state.
  logic [CNT_W-1:0]    sample_count, sample_count_next;
  logic [IDX_W-1:0]    play_index, play_index_next;
  logic [LEVEL_W-1:0]  driven_level, driven_level_next;
  logic [LEVEL_W-1:0]  pending_level, pending_level_next;
  logic [TIME_W-1:0]   due_cycle, due_cycle_next;
  logic [TIME_W-1:0]   base_cycle, base_cycle_next;
  logic [TIME_W-1:0]   base_wrap;
  logic [TIME_W-1:0]   now_plus1;
  logic [TIME_W-1:0]   now_plus2;
  logic                running, running_next;

  // Copy of sample 0 for restart, and the prefetched next sample.
  logic [OFFSET_W-1:0] first_offset;
  logic [LEVEL_W-1:0]  first_level;
  logic [OFFSET_W-1:0] pre_offset;
  logic [LEVEL_W-1:0]  pre_level;

  // Handshake and per-beat controls.
  logic                accept;
  logic                mem_we;
  logic [IDX_W-1:0]    rd_addr;
  logic [CNT_W-1:0]    next_pos;
  logic [CNT_W-1:0]    step_pos;
  logic                fire;
  logic                at_end;
  logic [TIME_W-1:0]   arm_base;
  logic [TIME_W-1:0]   arm_due;
  logic                changed_bit;
  logic                full_bit;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  // The period seen by the wrap adder includes a write in flight.
  always_comb begin
    repeat_period_next = repeat_period;
    if (cfg_write && cfg_index == CFG_REPEAT_PERIOD) begin
      repeat_period_next = cfg_data;
    end
  end

  assign fire     = accept && item.op == OP_TICK && running && now_plus1 >= due_cycle;
  assign step_pos = {1'b0, play_index} + CNT_W'(1);
  assign at_end   = step_pos >= sample_count;
  assign arm_base = at_end ? base_wrap : base_cycle;
  assign arm_due  = {{(TIME_W-OFFSET_W){1'b0}}, pre_offset} + arm_base;
  assign mem_we   = accept && item.op == OP_APPEND && sample_count < CNT_W'(TABLE_DEPTH);

  // Next-state logic for one accepted beat.
  always_comb begin
    sample_count_next  = sample_count;
    play_index_next    = play_index;
    driven_level_next  = driven_level;
    pending_level_next = pending_level;
    due_cycle_next     = due_cycle;
    base_cycle_next    = base_cycle;
    running_next       = running;
    changed_bit        = 1'b0;
    full_bit           = 1'b0;
    if (accept) begin
      case (item.op)
        OP_APPEND: begin
          if (mem_we) begin
            sample_count_next = sample_count + CNT_W'(1);
          end else begin
            full_bit = 1'b1;
          end
        end
        OP_RESTART: begin
          if (sample_count != '0) begin
            base_cycle_next    = item.start_time;
            driven_level_next  = initial_level;
            play_index_next    = '0;
            pending_level_next = first_level;
            due_cycle_next     = {{(TIME_W-OFFSET_W){1'b0}}, first_offset} + item.start_time;
            running_next       = 1'b1;
          end
        end
        OP_TICK: begin
          if (fire) begin
            driven_level_next = pending_level;
            changed_bit       = 1'b1;
            if (at_end && repeat_period == '0) begin
              running_next    = 1'b0;
              due_cycle_next  = '0;
              play_index_next = '0;
            end else begin
              play_index_next = at_end ? '0 : step_pos[IDX_W-1:0];
              if (at_end) begin
                base_cycle_next = base_wrap;
              end
              // A due time not after now is retried on the next tick.
              if (arm_due <= now_plus1) begin
                due_cycle_next = now_plus2;
              end else begin
                due_cycle_next     = arm_due;
                pending_level_next = pre_level;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Prefetch address: the sample after the next armed one.
  always_comb begin
    next_pos = {1'b0, play_index_next} + CNT_W'(1);
    rd_addr  = (next_pos >= sample_count_next) ? '0 : next_pos[IDX_W-1:0];
  end

  // Sample memory write port and registered read port with forwarding.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      offset_mem[sample_count[IDX_W-1:0]] <= item.sample_offset;
      level_mem[sample_count[IDX_W-1:0]]  <= item.sample_level;
    end
    if (mem_we && sample_count[IDX_W-1:0] == rd_addr) begin
      pre_offset <= item.sample_offset;
      pre_level  <= item.sample_level;
    end else begin
      pre_offset <= offset_mem[rd_addr];
      pre_level  <= level_mem[rd_addr];
    end
    if (mem_we && sample_count == '0) begin
      first_offset <= item.sample_offset;
      first_level  <= item.sample_level;
    end
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_period <= '0;
      initial_level <= '0;
      sample_count  <= '0;
      play_index    <= '0;
      driven_level  <= '0;
      pending_level <= '0;
      due_cycle     <= '0;
      base_cycle    <= '0;
      base_wrap     <= '0;
      now_plus1     <= TIME_W'(1);
      now_plus2     <= TIME_W'(2);
      running       <= 1'b0;
    end else begin
      repeat_period <= repeat_period_next;
      if (cfg_write && cfg_index == CFG_INITIAL_LEVEL) begin
        initial_level <= cfg_data[LEVEL_W-1:0];
      end
      sample_count  <= sample_count_next;
      play_index    <= play_index_next;
      driven_level  <= driven_level_next;
      pending_level <= pending_level_next;
      due_cycle     <= due_cycle_next;
      base_cycle    <= base_cycle_next;
      base_wrap     <= base_cycle_next + {{(TIME_W-PERIOD_W){1'b0}}, repeat_period_next};
      running       <= running_next;
      if (accept && item.op == OP_TICK) begin
        now_plus1 <= now_plus2;
        now_plus2 <= now_plus2 + TIME_W'(1);
      end
    end
  end

  // Result register, refilled as its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.level      <= driven_level_next;
      result.active     <= running_next;
      result.changed    <= changed_bit;
      result.table_full <= full_bit;
    end
  end

endmodule
`default_nettype wire
